// ===== rtl/plee_pkg.sv =====
// plee_pkg: shared types, codes and constants for the layered led effect engine
// used by the slot file, the serial arithmetic units and the top level
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package plee_pkg;

    // item operation codes
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_SET   = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    // pattern modes
    typedef enum logic [1:0] {
        MODE_OFF    = 2'd0,
        MODE_STATIC = 2'd1,
        MODE_BLINK  = 2'd2,
        MODE_PULSE  = 2'd3
    } t_mode;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SET_DIV,
        ST_SCAN,
        ST_PICK,
        ST_EL_MUL,
        ST_PH_DIV,
        ST_BR_DIV,
        ST_FL_MUL,
        ST_CH_GO,
        ST_CH_MUL,
        ST_EMIT
    } t_state;

    // one stored pattern
    typedef struct packed {
        t_mode       mode;
        logic [23:0] color;
        logic [15:0] period;
        logic [31:0] duration;
        logic [31:0] start;
        logic [31:0] expiry;
    } t_slot;

    // slot file commands
    typedef struct packed {
        logic wr;
        logic wr_exp;
        logic clr;
    } t_slot_cmd;

    // serial divider geometry
    localparam int DIV_DIVIDEND_W = 32;
    localparam int DIV_DIVISOR_W  = 16;
    localparam int DIV_CNT_W      = $clog2(DIV_DIVIDEND_W + 1);

    // serial multiplier geometry, product kept modulo 2^32
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 16;

    // configuration
    localparam int          INTERVAL_W            = 10;
    localparam logic [9:0]  INTERVAL_RESET        = 10'd10;
    localparam logic [0:0]  REG_IDX_TICK_INTERVAL = 1'b0;

    // effect constants
    localparam logic [15:0] BLINK_DEF_PERIOD = 16'd500;
    localparam logic [15:0] PULSE_DEF_PERIOD = 16'd1000;
    localparam logic [15:0] PULSE_MIN_PERIOD = 16'd2;
    localparam logic [15:0] BR_FULL          = 16'd65535;
    localparam logic [15:0] BR_FLOOR         = 16'd6553;
    localparam logic [15:0] BR_SPAN          = BR_FULL - BR_FLOOR;

    // x / 65535 without a divider, exact for x up to 65535 * 65535
    function automatic logic [15:0] div_by_full(input logic [31:0] x);
        logic [32:0] s;
        s = {1'b0, x} + {17'b0, x[31:16]} + 33'd1;
        return s[31:16];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/plee_serial_div.sv =====
// plee_serial_div: restoring divider, one quotient bit per cycle
// 32-bit dividend, 16-bit nonzero divisor; depends on plee_pkg
`timescale 1ns / 1ps
`default_nettype none

module plee_serial_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [plee_pkg::DIV_DIVIDEND_W-1:0] i_dividend,
    input  logic [plee_pkg::DIV_DIVISOR_W-1:0]  i_divisor,
    output logic                               o_done,
    output logic [plee_pkg::DIV_DIVIDEND_W-1:0] o_quot,
    output logic [plee_pkg::DIV_DIVISOR_W-1:0]  o_rem
);
    import plee_pkg::*;

    logic                      r_busy;
    logic                      r_done;
    logic [DIV_CNT_W-1:0]      r_cnt;
    logic [DIV_DIVIDEND_W-1:0] r_q;
    logic [DIV_DIVISOR_W-1:0]  r_r;
    logic [DIV_DIVISOR_W-1:0]  r_d;

    logic [DIV_DIVISOR_W:0]    w_trial;
    logic [DIV_DIVISOR_W:0]    w_diff;
    logic                      w_ge;

    // shift the next dividend bit into the partial remainder
    assign w_trial = {r_r, r_q[DIV_DIVIDEND_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_d};
    assign w_diff  = w_trial - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_r   <= '0;
            r_d   <= i_divisor;
            r_cnt <= DIV_CNT_W'(DIV_DIVIDEND_W);
        end else if (r_busy) begin
            r_q   <= {r_q[DIV_DIVIDEND_W-2:0], w_ge};
            r_r   <= w_ge ? w_diff[DIV_DIVISOR_W-1:0] : w_trial[DIV_DIVISOR_W-1:0];
            r_cnt <= r_cnt - DIV_CNT_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;

endmodule

`default_nettype wire

// ===== rtl/plee_serial_mul.sv =====
// plee_serial_mul: shift-and-add multiplier, one multiplier bit per cycle
// stops as soon as the remaining multiplier bits are zero; depends on plee_pkg
`timescale 1ns / 1ps
`default_nettype none

module plee_serial_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [plee_pkg::MUL_A_W-1:0] i_a,
    input  logic [plee_pkg::MUL_B_W-1:0] i_b,
    output logic                        o_done,
    output logic [plee_pkg::MUL_A_W-1:0] o_prod
);
    import plee_pkg::*;

    logic               r_busy;
    logic               r_done;
    logic [MUL_A_W-1:0] r_acc;
    logic [MUL_A_W-1:0] r_a;
    logic [MUL_B_W-1:0] r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_b == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
        end else if (r_busy && r_b != '0) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= {r_a[MUL_A_W-2:0], 1'b0};
            r_b <= {1'b0, r_b[MUL_B_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

`default_nettype wire

// ===== rtl/plee_slot_file.sv =====
// plee_slot_file: the priority slots, one pattern record and an active flag each
// one shared index for write, clear and read; depends on plee_pkg
`timescale 1ns / 1ps
`default_nettype none

module plee_slot_file #(
    parameter  int LAYERS = 4,
    localparam int IDX_W  = (LAYERS > 1) ? $clog2(LAYERS) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  plee_pkg::t_slot_cmd i_cmd,
    input  logic [IDX_W-1:0]    i_idx,
    input  plee_pkg::t_slot     i_rec,
    output plee_pkg::t_slot     o_rec,
    output logic                o_active
);
    import plee_pkg::*;

    t_slot             r_slot [LAYERS];
    logic [LAYERS-1:0] r_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else if (i_cmd.wr) begin
            r_active[i_idx] <= 1'b1;
        end else if (i_cmd.clr) begin
            r_active[i_idx] <= 1'b0;
        end
    end

    // expiry is only rewritten for patterns with a lifetime
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_slot[i_idx].mode     <= i_rec.mode;
            r_slot[i_idx].color    <= i_rec.color;
            r_slot[i_idx].period   <= i_rec.period;
            r_slot[i_idx].duration <= i_rec.duration;
            r_slot[i_idx].start    <= i_rec.start;
            if (i_cmd.wr_exp) begin
                r_slot[i_idx].expiry <= i_rec.expiry;
            end
        end
    end

    assign o_rec    = r_slot[i_idx];
    assign o_active = r_active[i_idx];

endmodule

`default_nettype wire

// ===== rtl/priority_layered_led_effect_engine_unit.sv =====
// priority_layered_led_effect_engine_unit: top level, sequencer, output register, apb register
// depends on plee_pkg, plee_slot_file, plee_serial_div, plee_serial_mul
`timescale 1ns / 1ps
`default_nettype none

// Layered LED effect engine. LAYERS priority slots each hold a pattern (off, static,
// blink or triangle pulse with a brightness floor) with an optional lifetime; the
// highest-numbered active slot wins. A set item stores a pattern and, for a nonzero
// lifetime, an expiry tick of tick_count + lifetime / tick_interval_ms. A clear
// item drops a slot. A tick item advances the tick counter, retires expired slots and
// delivers one LED colour item; set and clear items deliver nothing. Items are taken
// one at a time: a clear is done in the idle state, a set waits for the bit-serial
// divider, and a tick scans the slots and, for blink or pulse, waits for the serial
// arithmetic, pulse needing more of it, and then for the receiver to free the output
// register of the previous colour item. The tick cost is set by the one-slot-a-cycle
// scan, the shared bit-serial shift-add multiplier (elapsed time, floor mapping and
// the three colour channels in turn) and the shared bit-serial divider (phase and
// ramp). A finished colour item waits in the output register while the next item is
// accepted. tick_interval_ms sits at byte address 0 of the apb port (reset 10, a
// value of 0 acts as 1) and should only be written while idle.

module priority_layered_led_effect_engine_unit #(
    parameter int LAYERS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [2:0]  i_layer,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [15:0] i_period,
    input  logic [31:0] i_lifetime,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_led_on,
    output logic [7:0]  o_out_red,
    output logic [7:0]  o_out_green,
    output logic [7:0]  o_out_blue,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import plee_pkg::*;

    localparam int               IDX_W     = (LAYERS > 1) ? $clog2(LAYERS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(LAYERS - 1);
    localparam logic [3:0]       LAYER_LIM = 4'(LAYERS);
    localparam logic [1:0]       CH_LAST   = 2'd2;

    // control state
    t_state                r_state, n_state;
    logic [31:0]           r_tick, n_tick;
    logic [INTERVAL_W-1:0] r_interval, n_interval;
    logic                  r_out_valid, n_out_valid;

    // working registers
    logic [IDX_W-1:0]      r_scan, n_scan;
    logic [IDX_W-1:0]      r_sel, n_sel;
    logic                  r_found, n_found;
    t_mode                 r_mode, n_mode;
    logic [23:0]           r_color, n_color;
    logic [15:0]           r_p, n_p;
    logic [31:0]           r_dur, n_dur;
    logic                  r_rise, n_rise;
    logic [15:0]           r_br2, n_br2;
    logic [1:0]            r_ch, n_ch;
    logic                  r_res_on, n_res_on;
    logic [23:0]           r_res_color, n_res_color;
    logic                  r_out_on, n_out_on;
    logic [23:0]           r_out_color, n_out_color;

    // slot file
    t_slot_cmd             s_cmd;
    logic [IDX_W-1:0]      s_idx;
    t_slot                 s_rec_wr;
    t_slot                 s_rec_rd;
    logic                  s_active;

    // arithmetic units
    logic                  mul_start, mul_done;
    logic [MUL_A_W-1:0]    mul_a, mul_prod;
    logic [MUL_B_W-1:0]    mul_b;
    logic                  div_start, div_done;
    logic [DIV_DIVIDEND_W-1:0] div_dividend, div_quot;
    logic [DIV_DIVISOR_W-1:0]  div_divisor, div_rem;

    // derived values
    logic [INTERVAL_W-1:0] w_interval;
    logic                  w_cfg_wr;
    logic                  w_in_range;
    logic                  w_expired;
    logic [15:0]           w_pick_p;
    logic [15:0]           w_half;
    logic [15:0]           w_fall;
    logic                  w_phase_lo;
    logic [15:0]           w_br;
    logic [15:0]           w_scaled;
    logic [15:0]           w_br2;

    plee_slot_file #(
        .LAYERS (LAYERS)
    ) u_slots (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (s_cmd),
        .i_idx    (s_idx),
        .i_rec    (s_rec_wr),
        .o_rec    (s_rec_rd),
        .o_active (s_active)
    );

    plee_serial_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    plee_serial_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // apb register, zero-wait
    assign w_cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_IDX_TICK_INTERVAL);
    assign n_interval = w_cfg_wr ? pwdata[INTERVAL_W-1:0] : r_interval;
    assign prdata     = (paddr[2] == REG_IDX_TICK_INTERVAL) ?
                        {{(32 - INTERVAL_W){1'b0}}, r_interval} : '0;
    assign pready     = 1'b1;

    // an interval of zero behaves as one
    assign w_interval = (r_interval == '0) ? INTERVAL_W'(1) : r_interval;

    // layers beyond the slot count are ignored
    assign w_in_range = {1'b0, i_layer} < LAYER_LIM;

    // retire a timed pattern once the counter reaches its expiry
    assign w_expired  = (s_rec_rd.duration != '0) && (r_tick >= s_rec_rd.expiry);

    // effective period; pulse needs at least three so both ramps are nonzero
    assign w_pick_p   = (s_rec_rd.mode == MODE_BLINK) ?
                        ((s_rec_rd.period == '0) ? BLINK_DEF_PERIOD : s_rec_rd.period) :
                        ((s_rec_rd.period > PULSE_MIN_PERIOD) ? s_rec_rd.period :
                                                                PULSE_DEF_PERIOD);

    // phase arithmetic on the divider remainder
    assign w_half     = {1'b0, r_p[15:1]};
    assign w_phase_lo = div_rem < w_half;
    assign w_fall     = div_rem - w_half;

    // ramp brightness, rising or falling half
    assign w_br       = r_rise ? div_quot[15:0] : (BR_FULL - div_quot[15:0]);

    // product / 65535, reused for the floor mapping and the channel scaling
    assign w_scaled   = div_by_full(mul_prod);
    assign w_br2      = BR_FLOOR + w_scaled;

    // slot write record, only taken when a set item finishes
    always_comb begin
        s_rec_wr.mode     = r_mode;
        s_rec_wr.color    = r_color;
        s_rec_wr.period   = r_p;
        s_rec_wr.duration = r_dur;
        s_rec_wr.start    = r_tick;
        s_rec_wr.expiry   = r_tick + div_quot;
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_tick       = r_tick;
        n_out_valid  = r_out_valid && i_out_stall;
        n_scan       = r_scan;
        n_sel        = r_sel;
        n_found      = r_found;
        n_mode       = r_mode;
        n_color      = r_color;
        n_p          = r_p;
        n_dur        = r_dur;
        n_rise       = r_rise;
        n_br2        = r_br2;
        n_ch         = r_ch;
        n_res_on     = r_res_on;
        n_res_color  = r_res_color;
        n_out_on     = r_out_on;
        n_out_color  = r_out_color;
        s_cmd        = '0;
        s_idx        = r_sel;
        mul_start    = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;

        unique case (r_state)
            ST_IDLE: begin
                s_idx = i_layer[IDX_W-1:0];
                if (i_in_valid) begin
                    unique case (i_op)
                        OP_TICK: begin
                            n_tick  = r_tick + 32'd1;
                            n_scan  = LAST_IDX;
                            n_found = 1'b0;
                            n_state = ST_SCAN;
                        end
                        OP_SET: begin
                            if (w_in_range) begin
                                n_sel        = i_layer[IDX_W-1:0];
                                n_mode       = t_mode'(i_mode);
                                n_color      = {i_red, i_green, i_blue};
                                n_p          = i_period;
                                n_dur        = i_lifetime;
                                div_start    = 1'b1;
                                div_dividend = i_lifetime;
                                div_divisor  = {{(DIV_DIVISOR_W - INTERVAL_W){1'b0}}, w_interval};
                                n_state      = ST_SET_DIV;
                            end
                        end
                        OP_CLEAR: begin
                            s_cmd.clr = w_in_range;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // lifetime in ticks, then store the pattern
            ST_SET_DIV: begin
                if (div_done) begin
                    s_cmd.wr     = 1'b1;
                    s_cmd.wr_exp = (r_dur != '0);
                    n_state      = ST_IDLE;
                end
            end

            // top slot down: retire what has expired, remember the first survivor
            ST_SCAN: begin
                s_idx = r_scan;
                if (s_active) begin
                    if (w_expired) begin
                        s_cmd.clr = 1'b1;
                    end else if (!r_found) begin
                        n_found = 1'b1;
                        n_sel   = r_scan;
                    end
                end
                if (r_scan == '0) begin
                    n_state = ST_PICK;
                end else begin
                    n_scan = r_scan - IDX_W'(1);
                end
            end

            ST_PICK: begin
                n_mode  = s_rec_rd.mode;
                n_color = s_rec_rd.color;
                n_p     = w_pick_p;
                if (!r_found) begin
                    n_res_on    = 1'b0;
                    n_res_color = '0;
                    n_state     = ST_EMIT;
                end else begin
                    unique case (s_rec_rd.mode)
                        MODE_OFF: begin
                            n_res_on    = 1'b0;
                            n_res_color = '0;
                            n_state     = ST_EMIT;
                        end
                        MODE_STATIC: begin
                            n_res_on    = 1'b1;
                            n_res_color = s_rec_rd.color;
                            n_state     = ST_EMIT;
                        end
                        MODE_BLINK, MODE_PULSE: begin
                            // elapsed ms, modulo 2^32
                            mul_start = 1'b1;
                            mul_a     = r_tick - s_rec_rd.start;
                            mul_b     = {{(MUL_B_W - INTERVAL_W){1'b0}}, w_interval};
                            n_state   = ST_EL_MUL;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end

            // phase within the period
            ST_EL_MUL: begin
                if (mul_done) begin
                    div_start    = 1'b1;
                    div_dividend = mul_prod;
                    div_divisor  = r_p;
                    n_state      = ST_PH_DIV;
                end
            end

            ST_PH_DIV: begin
                if (div_done) begin
                    if (r_mode == MODE_BLINK) begin
                        // on in the first half of the period
                        n_res_on    = w_phase_lo;
                        n_res_color = w_phase_lo ? r_color : '0;
                        n_state     = ST_EMIT;
                    end else begin
                        // scale the phase to a 0..65535 ramp
                        n_rise    = w_phase_lo;
                        div_start = 1'b1;
                        if (w_phase_lo) begin
                            div_dividend = {div_rem, 16'b0} - {16'b0, div_rem};
                            div_divisor  = w_half;
                        end else begin
                            div_dividend = {w_fall, 16'b0} - {16'b0, w_fall};
                            div_divisor  = r_p - w_half;
                        end
                        n_state = ST_BR_DIV;
                    end
                end
            end

            // lift the ramp onto the brightness floor
            ST_BR_DIV: begin
                if (div_done) begin
                    mul_start = 1'b1;
                    mul_a     = {16'b0, w_br};
                    mul_b     = BR_SPAN;
                    n_state   = ST_FL_MUL;
                end
            end

            ST_FL_MUL: begin
                if (mul_done) begin
                    n_br2   = w_br2;
                    n_ch    = '0;
                    n_state = ST_CH_GO;
                end
            end

            // channels red, green, blue in turn off the top of the colour shift register
            ST_CH_GO: begin
                mul_start = 1'b1;
                mul_a     = {16'b0, r_br2};
                mul_b     = {8'b0, r_color[23:16]};
                n_state   = ST_CH_MUL;
            end

            ST_CH_MUL: begin
                if (mul_done) begin
                    n_res_color = {r_res_color[15:0], w_scaled[7:0]};
                    n_color     = {r_color[15:0], 8'b0};
                    if (r_ch == CH_LAST) begin
                        n_res_on = 1'b1;
                        n_state  = ST_EMIT;
                    end else begin
                        n_ch    = r_ch + 2'd1;
                        n_state = ST_CH_GO;
                    end
                end
            end

            // hand over to the output register once it is free
            ST_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_on    = r_res_on;
                    n_out_color = r_res_color;
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tick      <= '0;
            r_interval  <= INTERVAL_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tick      <= n_tick;
            r_interval  <= n_interval;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan      <= n_scan;
        r_sel       <= n_sel;
        r_found     <= n_found;
        r_mode      <= n_mode;
        r_color     <= n_color;
        r_p         <= n_p;
        r_dur       <= n_dur;
        r_rise      <= n_rise;
        r_br2       <= n_br2;
        r_ch        <= n_ch;
        r_res_on    <= n_res_on;
        r_res_color <= n_res_color;
        r_out_on    <= n_out_on;
        r_out_color <= n_out_color;
    end

    // items are taken only between operations
    assign o_in_stall  = (r_state != ST_IDLE);

    assign o_out_valid = r_out_valid;
    assign o_led_on    = r_out_on;
    assign o_out_red   = r_out_color[23:16];
    assign o_out_green = r_out_color[15:8];
    assign o_out_blue  = r_out_color[7:0];

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// tb: self-checking testbench for priority_layered_led_effect_engine_unit
// drives set, clear and tick items plus apb writes of the tick interval, predicts every led item
// depends on plee_pkg and priority_layered_led_effect_engine_unit
`timescale 1ns / 1ps

module tb;

    import plee_pkg::*;

    localparam int NUM_LAYERS = 4;

    // op code that the block ignores
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // byte address of the tick interval register
    localparam logic [2:0] ADDR_TICK_INTERVAL = {REG_IDX_TICK_INTERVAL, 2'b00};

    // wide copies of the effect constants for the predictor arithmetic
    localparam logic [31:0] FULL_W  = {16'd0, BR_FULL};
    localparam logic [31:0] FLOOR_W = {16'd0, BR_FLOOR};
    localparam logic [31:0] SPAN_W  = {16'd0, BR_SPAN};

    localparam int SETTLE_CYCLES  = 200;   // settle time after draining; covers a set still busy in the divider
    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 5000;  // cycles with no accepted item or apb access

    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  layer;
        logic [1:0]  mode;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] period;
        logic [31:0] lifetime;
    } t_led_item;

    typedef struct packed {
        logic       on;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_led_colour;

    // clock, reset and block ports
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_op = '0;
    logic [2:0]  i_layer = '0;
    logic [1:0]  i_mode = '0;
    logic [7:0]  i_red = '0;
    logic [7:0]  i_green = '0;
    logic [7:0]  i_blue = '0;
    logic [15:0] i_period = '0;
    logic [31:0] i_lifetime = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_led_on;
    logic [7:0]  o_out_red;
    logic [7:0]  o_out_green;
    logic [7:0]  o_out_blue;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // items waiting for the driver and led items still to arrive
    t_led_item   pending_items[$];
    t_led_colour led_expect[$];

    // shadow of the engine state
    logic [9:0]  interval_reg;
    logic [31:0] tick_cnt;
    logic        slot_on  [NUM_LAYERS];
    t_mode       slot_md  [NUM_LAYERS];
    logic [7:0]  slot_r   [NUM_LAYERS];
    logic [7:0]  slot_g   [NUM_LAYERS];
    logic [7:0]  slot_b   [NUM_LAYERS];
    logic [15:0] slot_per [NUM_LAYERS];
    logic [31:0] slot_dur [NUM_LAYERS];
    logic [31:0] slot_st  [NUM_LAYERS];
    logic [31:0] slot_exp [NUM_LAYERS];

    // idling controls, set by the sequencer at falling edges
    int in_idle_pct  = 0;
    int out_idle_pct = 0;
    int hold_req_cnt = 0;
    int fail_count   = 0;

    priority_layered_led_effect_engine_unit #(
        .LAYERS(NUM_LAYERS)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_layer      (i_layer),
        .i_mode       (i_mode),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .i_period     (i_period),
        .i_lifetime   (i_lifetime),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_led_on     (o_led_on),
        .o_out_red    (o_out_red),
        .o_out_green  (o_out_green),
        .o_out_blue   (o_out_blue),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // 8 ns clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // reset held low at the start, then released once
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ---------------------------------------------------------------
    // led colour of one slot at the current tick
    // ---------------------------------------------------------------
    function automatic t_led_colour slot_colour(input int idx);
        t_led_colour res;
        logic [31:0] eff;
        logic [31:0] elapsed;
        logic [31:0] p;
        logic [31:0] half;
        logic [31:0] phase;
        logic [31:0] br;
        logic [31:0] ch_r;
        logic [31:0] ch_g;
        logic [31:0] ch_b;
        res = '0;
        eff = (interval_reg == 10'd0) ? 32'd1 : {22'd0, interval_reg};
        elapsed = (tick_cnt - slot_st[idx]) * eff;
        case (slot_md[idx])
            MODE_STATIC: begin
                res = '{1'b1, slot_r[idx], slot_g[idx], slot_b[idx]};
            end
            MODE_BLINK: begin
                p = (slot_per[idx] == 16'd0) ? {16'd0, BLINK_DEF_PERIOD}
                                             : {16'd0, slot_per[idx]};
                // on during the first half period; a period of one never lights
                if ((elapsed % p) < (p / 32'd2))
                    res = '{1'b1, slot_r[idx], slot_g[idx], slot_b[idx]};
            end
            MODE_PULSE: begin
                p = (slot_per[idx] > PULSE_MIN_PERIOD) ? {16'd0, slot_per[idx]}
                                                       : {16'd0, PULSE_DEF_PERIOD};
                half  = p / 32'd2;
                phase = elapsed % p;
                // triangle ramp up then down
                if (phase < half)
                    br = (phase * FULL_W) / half;
                else
                    br = FULL_W - ((phase - half) * FULL_W) / (p - half);
                // lift onto the brightness floor
                br = FLOOR_W + (SPAN_W * br) / FULL_W;
                ch_r = ({24'd0, slot_r[idx]} * br) / FULL_W;
                ch_g = ({24'd0, slot_g[idx]} * br) / FULL_W;
                ch_b = ({24'd0, slot_b[idx]} * br) / FULL_W;
                res = '{1'b1, ch_r[7:0], ch_g[7:0], ch_b[7:0]};
            end
            default: begin
                res = '0;
            end
        endcase
        return res;
    endfunction

    // ---------------------------------------------------------------
    // advance the shadow engine by one accepted item
    // ---------------------------------------------------------------
    task automatic engine_step(input t_led_item it);
        int top;
        logic [31:0] eff;
        t_led_colour res;
        eff = (interval_reg == 10'd0) ? 32'd1 : {22'd0, interval_reg};
        if (it.op == OP_TICK) begin
            tick_cnt = tick_cnt + 32'd1;
            top = -1;
            // retire expired slots, remember the highest survivor
            for (int i = NUM_LAYERS - 1; i >= 0; i--) begin
                if (slot_on[i]) begin
                    if (slot_dur[i] != 32'd0 && tick_cnt >= slot_exp[i])
                        slot_on[i] = 1'b0;
                    else if (top < 0)
                        top = i;
                end
            end
            if (top < 0)
                res = '0;
            else
                res = slot_colour(top);
            led_expect.push_back(res);
        end else if (it.op == OP_SET && it.layer < NUM_LAYERS) begin
            slot_md[it.layer]  = t_mode'(it.mode);
            slot_r[it.layer]   = it.red;
            slot_g[it.layer]   = it.green;
            slot_b[it.layer]   = it.blue;
            slot_per[it.layer] = it.period;
            slot_dur[it.layer] = it.lifetime;
            slot_on[it.layer]  = 1'b1;
            slot_st[it.layer]  = tick_cnt;
            // zero lifetime keeps the old expiry, which is then unused
            if (it.lifetime != 32'd0)
                slot_exp[it.layer] = tick_cnt + it.lifetime / eff;
        end else if (it.op == OP_CLEAR && it.layer < NUM_LAYERS) begin
            slot_on[it.layer] = 1'b0;
        end
        // unused op and out-of-range layers leave the state alone
    endtask

    // ---------------------------------------------------------------
    // item driver: presents queued items, random gaps after an accept
    // ---------------------------------------------------------------
    t_led_item cur_item = '0;
    int        in_gap = 0;

    always @(posedge i_clk) begin : item_driver
        logic fire;
        logic nxt_valid;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap = 0;
        end else begin
            fire = i_in_valid && !o_in_stall;
            nxt_valid = i_in_valid;
            if (fire)
                engine_step(cur_item);
            // a stalled item stays put; otherwise load the next one or idle
            if (fire || !i_in_valid) begin
                nxt_valid = 1'b0;
                if (fire && in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct)
                    in_gap = $urandom_range(1, 6);
                if (in_gap > 0) begin
                    in_gap--;
                end else if (pending_items.size() != 0) begin
                    cur_item = pending_items.pop_front();
                    i_op       <= cur_item.op;
                    i_layer    <= cur_item.layer;
                    i_mode     <= cur_item.mode;
                    i_red      <= cur_item.red;
                    i_green    <= cur_item.green;
                    i_blue     <= cur_item.blue;
                    i_period   <= cur_item.period;
                    i_lifetime <= cur_item.lifetime;
                    nxt_valid = 1'b1;
                end
            end
            i_in_valid <= nxt_valid;
        end
    end

    // ---------------------------------------------------------------
    // receiver stall: short random bursts plus the long hold-off
    // ---------------------------------------------------------------
    int out_burst = 0;
    int hold_left = 0;
    int hold_seen = 0;

    always @(posedge i_clk) begin : led_stall_gen
        logic nxt_stall;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (hold_req_cnt != hold_seen) begin
                hold_seen = hold_req_cnt;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                nxt_stall = 1'b1;
            end else if (out_burst > 0) begin
                out_burst--;
                nxt_stall = 1'b1;
            end else if (out_idle_pct != 0 && $urandom_range(0, 99) < out_idle_pct) begin
                out_burst = $urandom_range(1, 6) - 1;
                nxt_stall = 1'b1;
            end else begin
                nxt_stall = 1'b0;
            end
            i_out_stall <= nxt_stall;
        end
    end

    // ---------------------------------------------------------------
    // led monitor: each accepted led item against the oldest prediction
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : led_monitor
        t_led_colour want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (led_expect.size() == 0) begin
                $error("led item with no prediction waiting");
                fail_count++;
            end else begin
                want = led_expect.pop_front();
                if (o_led_on !== want.on) begin
                    $error("led_on mismatch: expected %0d, actual %0d", want.on, o_led_on);
                    fail_count++;
                end
                if (o_out_red !== want.red) begin
                    $error("out_red mismatch: expected %0d, actual %0d", want.red, o_out_red);
                    fail_count++;
                end
                if (o_out_green !== want.green) begin
                    $error("out_green mismatch: expected %0d, actual %0d",
                           want.green, o_out_green);
                    fail_count++;
                end
                if (o_out_blue !== want.blue) begin
                    $error("out_blue mismatch: expected %0d, actual %0d", want.blue, o_out_blue);
                    fail_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // watchdog: too long without any accepted item or apb access
    // ---------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("priority_layered_led_effect_engine_unit test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    task automatic push_item(input logic [1:0] op, input logic [2:0] layer,
                             input logic [1:0] mode, input logic [7:0] r,
                             input logic [7:0] g, input logic [7:0] b,
                             input logic [15:0] per, input logic [31:0] dur);
        pending_items.push_back('{op, layer, mode, r, g, b, per, dur});
    endtask

    function automatic logic [7:0] pick_channel();
        int sel;
        sel = $urandom_range(0, 5);
        if (sel == 0)
            return 8'd0;
        else if (sel == 1)
            return 8'hFF;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [15:0] pick_period();
        int sel;
        sel = $urandom_range(0, 5);
        case (sel)
            0: return 16'd0;
            1: return 16'($urandom_range(1, 3));
            2: return 16'($urandom_range(4, 64));
            3: return 16'($urandom_range(65, 2000));
            4: return 16'($urandom);
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic logic [31:0] pick_duration(input logic [31:0] eff);
        int sel;
        sel = $urandom_range(0, 5);
        case (sel)
            0, 1: return 32'd0;
            // at most one tick: expires on the next tick
            2: return 32'($urandom_range(1, eff));
            3: return eff * 32'($urandom_range(1, 30)) + 32'($urandom_range(0, eff - 1));
            4: return 32'($urandom);
            default: return 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
        endcase
    endfunction

    function automatic t_led_item random_item(input logic [1:0] op, input logic [2:0] layer);
        t_led_item it;
        logic [31:0] eff;
        eff = (interval_reg == 10'd0) ? 32'd1 : {22'd0, interval_reg};
        it.op       = op;
        it.layer    = layer;
        it.mode     = 2'($urandom_range(0, 3));
        it.red      = pick_channel();
        it.green    = pick_channel();
        it.blue     = pick_channel();
        it.period   = pick_period();
        it.lifetime = pick_duration(eff);
        return it;
    endfunction

    // mostly tick runs between sets, some clears, a little noise
    task automatic add_random(input int n);
        int added;
        int sel;
        int run;
        added = 0;
        while (added < n) begin
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
                run = $urandom_range(1, 12);
                repeat (run) pending_items.push_back(random_item(OP_TICK, 3'($urandom)));
                added += run;
            end else if (sel < 82) begin
                pending_items.push_back(
                    random_item(OP_SET, 3'($urandom_range(0, NUM_LAYERS - 1))));
                added++;
            end else if (sel < 92) begin
                pending_items.push_back(
                    random_item(OP_CLEAR, 3'($urandom_range(0, NUM_LAYERS - 1))));
                added++;
            end else begin
                // ignored items: unused op or a layer beyond the slots
                sel = $urandom_range(0, 2);
                if (sel == 0)
                    pending_items.push_back(random_item(OP_UNUSED, 3'($urandom)));
                else
                    pending_items.push_back(random_item(sel == 1 ? OP_SET : OP_CLEAR,
                                            3'($urandom_range(NUM_LAYERS, 7))));
                added++;
            end
        end
    endtask

    // wait until every item is in and every led item out, then let the block settle
    task automatic wait_drained();
        while (pending_items.size() != 0 || i_in_valid || led_expect.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // apb write of the tick interval, setup phase then access phase
    task automatic write_interval(input logic [9:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_TICK_INTERVAL;
        pwdata  <= {22'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        interval_reg = val;
        @(negedge i_clk);
    endtask

    task automatic run_phase(input logic [9:0] interval, input int n,
                             input int idle_pct, input bit long_hold);
        wait_drained();
        write_interval(interval);
        in_idle_pct  = idle_pct;
        out_idle_pct = idle_pct;
        add_random(n);
        if (long_hold)
            hold_req_cnt++;
    endtask

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    initial begin
        interval_reg = INTERVAL_RESET;
        tick_cnt = '0;
        for (int i = 0; i < NUM_LAYERS; i++) begin
            slot_on[i]  = 1'b0;
            slot_md[i]  = MODE_OFF;
            slot_r[i]   = '0;
            slot_g[i]   = '0;
            slot_b[i]   = '0;
            slot_per[i] = '0;
            slot_dur[i] = '0;
            slot_st[i]  = '0;
            slot_exp[i] = '0;
        end
        wait (i_rst_n);
        @(negedge i_clk);

        // directed part at the reset interval
        in_idle_pct  = 20;
        out_idle_pct = 20;
        push_item(OP_TICK,   3'd0, MODE_OFF,    8'd0,   8'd0,   8'd0,   16'd0, 32'd0);
        push_item(OP_SET,    3'd0, MODE_STATIC, 8'hFF,  8'd0,   8'hFF,  16'd0, 32'd0);
        push_item(OP_TICK,   3'd0, MODE_OFF,    8'd0,   8'd0,   8'd0,   16'd0, 32'd0);
        // blink with the default period
        push_item(OP_SET,    3'd3, MODE_BLINK,  8'd0,   8'hFF,  8'd0,   16'd0, 32'd0);
        push_item(OP_TICK,   3'd0, MODE_OFF,    8'd0,   8'd0,   8'd0,   16'd0, 32'd0);
        // pulse with a period too short, falls back to the default
        push_item(OP_SET,    3'd2, MODE_PULSE,  8'hFF,  8'hFF,  8'hFF,  16'd2, 32'd0);
        push_item(OP_CLEAR,  3'd3, MODE_OFF,    8'd0,   8'd0,   8'd0,   16'd0, 32'd0);
        push_item(OP_TICK,   3'd0, MODE_OFF,    8'd0,   8'd0,   8'd0,   16'd0, 32'd0);
        push_item(OP_TICK,   3'd7, MODE_PULSE,  8'hFF,  8'hFF,  8'hFF,  16'hFFFF, 32'hFFFF_FFFF);
        // layers beyond the slots and the unused op are dropped
        push_item(OP_SET,    3'd7, MODE_STATIC, 8'hFF,  8'hFF,  8'hFF,  16'hFFFF, 32'hFFFF_FFFF);
        push_item(OP_CLEAR,  3'd5, MODE_OFF,    8'd0,   8'd0,   8'd0,   16'd0, 32'd0);
        push_item(OP_UNUSED, 3'd2, MODE_STATIC, 8'd9,   8'd9,   8'd9,   16'd0, 32'd0);
        push_item(OP_TICK,   3'd0, MODE_OFF,    8'd0,   8'd0,   8'd0,   16'd0, 32'd0);
        // blink period of one never lights
        push_item(OP_SET,    3'd3, MODE_BLINK,  8'hFF,  8'hFF,  8'hFF,  16'd1, 32'd0);
        push_item(OP_TICK,   3'd0, MODE_OFF,    8'd0,   8'd0,   8'd0,   16'd0, 32'd0);
        // top slot in off mode hides the lower ones
        push_item(OP_SET,    3'd3, MODE_OFF,    8'hFF,  8'hFF,  8'hFF,  16'd0, 32'd0);
        push_item(OP_TICK,   3'd0, MODE_OFF,    8'd0,   8'd0,   8'd0,   16'd0, 32'd0);
        // short lifetime: shown on one tick, retired on the next
        push_item(OP_SET,    3'd3, MODE_STATIC, 8'd1,   8'd2,   8'd3,   16'd0, 32'd25);
        push_item(OP_TICK,   3'd0, MODE_OFF,    8'd0,   8'd0,   8'd0,   16'd0, 32'd0);
        push_item(OP_TICK,   3'd0, MODE_OFF,    8'd0,   8'd0,   8'd0,   16'd0, 32'd0);
        push_item(OP_TICK,   3'd0, MODE_OFF,    8'd0,   8'd0,   8'd0,   16'd0, 32'd0);
        // longest period and lifetime
        push_item(OP_SET,    3'd3, MODE_PULSE,  8'hFF,  8'h80,  8'h01,  16'hFFFF, 32'hFFFF_FFFF);
        push_item(OP_TICK,   3'd0, MODE_OFF,    8'd0,   8'd0,   8'd0,   16'd0, 32'd0);
        push_item(OP_CLEAR,  3'd3, MODE_OFF,    8'd0,   8'd0,   8'd0,   16'd0, 32'd0);
        push_item(OP_CLEAR,  3'd2, MODE_OFF,    8'd0,   8'd0,   8'd0,   16'd0, 32'd0);
        // shortest pulse period that is kept
        push_item(OP_SET,    3'd1, MODE_PULSE,  8'hFF,  8'hFF,  8'hFF,  16'd3, 32'd0);
        push_item(OP_TICK,   3'd0, MODE_OFF,    8'd0,   8'd0,   8'd0,   16'd0, 32'd0);

        // random phases over several intervals; long receiver hold-off in the first
        run_phase(10'd1,    250, 20, 1'b1);
        run_phase(10'd1000, 200, 25, 1'b0);
        run_phase(10'd0,    150, 0,  1'b0);
        run_phase(10'd1023, 150, 30, 1'b0);
        run_phase(10'($urandom_range(2, 999)), 200, 15, 1'b0);
        // closing stretch with no idling on either side
        run_phase(INTERVAL_RESET, 175, 0, 1'b0);

        wait_drained();
        if (fail_count == 0 && led_expect.size() == 0) begin
            $display("priority_layered_led_effect_engine_unit test passed");
        end else begin
            $display("priority_layered_led_effect_engine_unit test failed");
        end
        $finish;
    end

endmodule
